/* hdl/bounded_distance_transform_2d_assert.svh */
// assertion macros for the bounded distance transform
`ifndef BOUNDED_DISTANCE_TRANSFORM_2D_ASSERT_SVH
`define BOUNDED_DISTANCE_TRANSFORM_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define BDT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BDT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BDT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* hdl/bdt_pkg.sv */
// shared types and constants for the bounded distance transform
`timescale 1ns / 1ps
package bdt_pkg;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdxW = 6;
  localparam int unsigned DimW = 7;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS = 3'd0,
    CFG_COLS = 3'd1,
    CFG_AX   = 3'd2,
    CFG_BX   = 3'd3,
    CFG_AY   = 3'd4,
    CFG_BY   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                     kind;
    logic signed [ScoreW-1:0] score;
  } in_beat_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] value;
    logic [IdxW-1:0]          col_index;
    logic [IdxW-1:0]          row_index;
    logic                     last;
    logic                     not_ready;
  } out_beat_t;

  function automatic logic signed [ScoreW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[ScoreW-1:0];
  endfunction
endpackage

/* hdl/bdt_if.sv */
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface bdt_in_if import bdt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdt_out_if import bdt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/bdt_cand.sv */
// candidate cost unit: v - a*d*d - b*d, two register stages
`timescale 1ns / 1ps
module bdt_cand import bdt_pkg::*; #(
  parameter int unsigned DW = 5
) (
  input  logic                     clk_i,
  input  logic signed [ScoreW-1:0] v_i,
  input  logic signed [DW-1:0]     d_i,
  input  logic signed [ScoreW-1:0] a_i,
  input  logic signed [ScoreW-1:0] b_i,
  output logic signed [65:0]       cand_o
);
  logic signed [2*DW-1:0] dd;
  logic signed [ScoreW+2*DW-1:0] pa_q, pb_q;
  logic signed [ScoreW-1:0] v_q;
  assign dd = d_i * d_i;
  always_ff @(posedge clk_i) begin
    pa_q <= a_i * dd;
    pb_q <= b_i * d_i;
    v_q  <= v_i;
  end
  always_ff @(posedge clk_i) begin
    cand_o <= 66'(v_q) - 66'(pa_q) - 66'(pb_q);
  end
endmodule

/* hdl/bounded_distance_transform_2d.sv */
// top level: bounded 2-d distance transform over a stored score map
// channel | dir | beat fields
// in_ch   | in  | kind, score
// out_ch  | out | value, col_index, row_index, last, not_ready
// a load is written as it is taken; a read steps through S_RD1, S_RD2 and S_RD3, and its result is registered in S_RD3
// after the last load, each pass sweeps every pixel with up to 2*WINDOW_HALF+1 window reads,
// one memory read a cycle, and the transform blocks input until both passes are done
// reset clears the counters, flags and configuration; the memories hold garbage until written
// an output register holds a result until taken; no new item is taken meanwhile
`timescale 1ns / 1ps
`include "bounded_distance_transform_2d_assert.svh"
module bounded_distance_transform_2d import bdt_pkg::*; #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned WINDOW_HALF = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bdt_in_if.sink             in_ch,
  bdt_out_if.source          out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ScoreW-1:0]  cfg_data_i
);
  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned KW = $clog2(MAX_COLS + 1);
  localparam int unsigned LW = (RW > KW) ? RW : KW;
  localparam int unsigned DW = $clog2(WINDOW_HALF + 1) + 1;
  localparam int unsigned WN = 2 * WINDOW_HALF + 1;
  localparam int unsigned JW = $clog2(WN + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PIX   = 7'b0000010,
    S_WIN   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_RD1   = 7'b0010000,
    S_RD2   = 7'b0100000,
    S_RD3   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [DimW-1:0] rows_cfg_q, cols_cfg_q;
  logic signed [ScoreW-1:0] ax_q, bx_q, ay_q, by_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DimW'(64);
      cols_cfg_q <= DimW'(64);
      ax_q <= '0; bx_q <= '0; ay_q <= '0; by_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_cfg_q <= cfg_data_i[DimW-1:0];
        CFG_COLS: cols_cfg_q <= cfg_data_i[DimW-1:0];
        CFG_AX:   ax_q <= cfg_data_i;
        CFG_BX:   bx_q <= cfg_data_i;
        CFG_AY:   ay_q <= cfg_data_i;
        CFG_BY:   by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LW-1:0] rows_cl, cols_cl;
  always_comb begin
    if (rows_cfg_q == '0) rows_cl = LW'(1);
    else if (32'(rows_cfg_q) > MAX_ROWS) rows_cl = LW'(MAX_ROWS);
    else rows_cl = LW'(rows_cfg_q);
    if (cols_cfg_q == '0) cols_cl = LW'(1);
    else if (32'(cols_cfg_q) > MAX_COLS) cols_cl = LW'(MAX_COLS);
    else cols_cl = LW'(cols_cfg_q);
  end

  // memories
  logic signed [ScoreW-1:0] score_mem [Depth];
  logic signed [ScoreW-1:0] cmax_mem [Depth];
  logic [IdxW-1:0]          carg_mem [Depth];
  logic signed [ScoreW-1:0] rval_mem [Depth];
  logic [IdxW-1:0]          rcol_mem [Depth];

  // counters and flags
  logic [CW-1:0] load_cnt_q, read_cnt_q;
  logic          ready_q;
  logic [LW-1:0] hrows_q, hcols_q;
  logic [2*LW-1:0] total;
  assign total = hrows_q * hcols_q;

  // sweep control
  logic          pass_q;            // 0 column pass, 1 row pass
  logic [LW-1:0] line_q, pos_q;     // line and position within line
  logic [JW-1:0] j_q;               // window offset counter
  logic [LW-1:0] n_len, n_lines;
  assign n_len   = pass_q ? hcols_q : hrows_q;
  assign n_lines = pass_q ? hrows_q : hcols_q;

  logic signed [LW+1:0] lo_s, hi_s;
  logic signed [LW+1:0] jpos;
  always_comb begin
    lo_s = $signed({2'b00, pos_q}) - (LW+2)'(WINDOW_HALF);
    if (lo_s < 0) lo_s = '0;
    hi_s = $signed({2'b00, pos_q}) + (LW+2)'(WINDOW_HALF);
    if (hi_s > $signed({2'b00, n_len}) - 1) hi_s = $signed({2'b00, n_len}) - 1;
    jpos = lo_s + $signed({{(LW+2-JW){1'b0}}, j_q});
  end
  logic win_issue;
  assign win_issue = (state_q == S_WIN) && (jpos <= hi_s);

  function automatic logic [AW-1:0] addr_of(input logic p, input logic [LW-1:0] ln,
                                           input logic [LW-1:0] ps, input logic [LW-1:0] nc);
    logic [2*LW-1:0] a;
    if (p) a = ln * nc + (2*LW)'(ps);
    else   a = ps * nc + (2*LW)'(ln);
    addr_of = a[AW-1:0];
  endfunction

  logic [AW-1:0] rd_addr;
  assign rd_addr = addr_of(pass_q, line_q, jpos[LW-1:0], hcols_q);

  // window read pipe: read (1) -> cand stage a (2) -> cand out (3)
  logic signed [ScoreW-1:0] rd_data_q;
  logic [2:0]               vld_q;
  logic signed [DW-1:0]     d_p [2];
  logic [IdxW-1:0]          jidx_p [3];
  logic [2:0]               first_p;
  logic signed [LW+1:0]     dfull;
  assign dfull = $signed({2'b00, pos_q}) - jpos;

  always_ff @(posedge clk_i) begin
    rd_data_q <= pass_q ? cmax_mem[rd_addr] : score_mem[rd_addr];
    d_p[0] <= dfull[DW-1:0];
    d_p[1] <= d_p[0];
    jidx_p[0] <= jpos[IdxW-1:0];
    jidx_p[1] <= jidx_p[0];
    jidx_p[2] <= jidx_p[1];
    first_p <= {first_p[1:0], (j_q == '0)};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[1:0], win_issue};
  end

  logic signed [65:0] cand;
  bdt_cand #(.DW(DW)) u_cand (
    .clk_i  (clk_i),
    .v_i    (rd_data_q),
    .d_i    (d_p[0]),
    .a_i    (pass_q ? ax_q : ay_q),
    .b_i    (pass_q ? bx_q : by_q),
    .cand_o (cand)
  );

  logic signed [65:0] best_q;
  logic [IdxW-1:0]    bestj_q;
  logic signed [65:0] best_n;
  logic [IdxW-1:0]    bestj_n;
  always_comb begin
    best_n = best_q;
    bestj_n = bestj_q;
    if (vld_q[2] && (first_p[2] || cand > best_q)) begin
      best_n = cand;
      bestj_n = jidx_p[2];
    end
  end
  always_ff @(posedge clk_i) begin
    best_q <= best_n;
    bestj_q <= bestj_n;
  end

  logic [AW-1:0] wr_addr;
  assign wr_addr = addr_of(pass_q, line_q, pos_q, hcols_q);

  // read path
  logic [AW-1:0] rk_q, ra_addr;
  logic signed [ScoreW-1:0] rv_q;
  logic [IdxW-1:0] rc_q, ra_q;
  logic [2*LW-1:0] rbase;
  logic [LW-1:0] rrow_q, rcol_q;
  assign rbase = rrow_q * hcols_q;
  assign ra_addr = AW'(rbase) + AW'(rc_q);

  out_beat_t out_q;
  logic      out_v_q;

  logic in_acc, out_acc;
  assign in_ch.ready = (state_q == S_IDLE) && !out_v_q;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_v_q && out_ch.ready;
  assign out_ch.valid = out_v_q;
  assign out_ch.data = out_q;

  logic load_go, full_after;
  assign load_go = in_acc && !in_ch.data.kind && !ready_q;
  assign full_after = (2*LW+1)'(load_cnt_q) + 1 >=
                      (2*LW+1)'(rows_cl) * (2*LW+1)'(cols_cl);

  always_ff @(posedge clk_i) begin
    if (load_go && load_cnt_q < CW'(Depth))
      score_mem[load_cnt_q[AW-1:0]] <= in_ch.data.score;
    if (state_q == S_DRAIN && vld_q == '0 && !pass_q) begin
      cmax_mem[wr_addr] <= sat32(best_q);
      carg_mem[wr_addr] <= bestj_q;
    end
    if (state_q == S_DRAIN && vld_q == '0 && pass_q) begin
      rval_mem[wr_addr] <= sat32(best_q);
      rcol_mem[wr_addr] <= bestj_q;
    end
    rv_q <= rval_mem[rk_q];
    rc_q <= rcol_mem[rk_q];
    ra_q <= carg_mem[ra_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) begin
        if (!in_ch.data.kind) begin
          if (load_go && full_after) state_d = S_PIX;
        end else if (ready_q) state_d = S_RD1;
      end
      S_PIX: state_d = S_WIN;
      S_WIN: if (!win_issue) state_d = S_DRAIN;
      S_DRAIN: if (vld_q == '0) begin
        if (pos_q + 1 < n_len || line_q + 1 < n_lines || !pass_q) state_d = S_PIX;
        else state_d = S_IDLE;
      end
      S_RD1: state_d = S_RD2;
      S_RD2: state_d = S_RD3;
      S_RD3: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      ready_q <= 1'b0;
      hrows_q <= LW'(MAX_ROWS);
      hcols_q <= LW'(MAX_COLS);
      pass_q <= 1'b0;
      line_q <= '0;
      pos_q <= '0;
      j_q <= '0;
      out_v_q <= 1'b0;
      out_q <= '0;
      rk_q <= '0;
      rrow_q <= '0;
      rcol_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_acc) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          if (!in_ch.data.kind) begin
            if (load_go) begin
              load_cnt_q <= load_cnt_q + 1'b1;
              if (full_after) begin
                hrows_q <= rows_cl;
                hcols_q <= cols_cl;
                pass_q <= 1'b0;
                line_q <= '0;
                pos_q <= '0;
              end
            end
          end else if (!ready_q) begin
            out_q <= '{value: '0, col_index: '0, row_index: '0, last: 1'b0,
                       not_ready: 1'b1};
            out_v_q <= 1'b1;
          end else begin
            rk_q <= read_cnt_q[AW-1:0];
          end
        end
        S_PIX: j_q <= '0;
        S_WIN: if (win_issue) j_q <= j_q + 1'b1;
        S_DRAIN: if (vld_q == '0) begin
          if (pos_q + 1 < n_len) pos_q <= pos_q + 1'b1;
          else begin
            pos_q <= '0;
            if (line_q + 1 < n_lines) line_q <= line_q + 1'b1;
            else begin
              line_q <= '0;
              if (!pass_q) pass_q <= 1'b1;
              else begin
                ready_q <= 1'b1;
                read_cnt_q <= '0;
              end
            end
          end
        end
        S_RD3: begin
          out_q <= '{value: rv_q, col_index: rc_q, row_index: ra_q,
                     last: ((2*LW+1)'(read_cnt_q) + 1 >= (2*LW+1)'(total)),
                     not_ready: 1'b0};
          out_v_q <= 1'b1;
          if ((2*LW+1)'(read_cnt_q) + 1 >= (2*LW+1)'(total)) begin
            ready_q <= 1'b0;
            load_cnt_q <= '0;
            read_cnt_q <= '0;
            rrow_q <= '0;
            rcol_q <= '0;
          end else begin
            read_cnt_q <= read_cnt_q + 1'b1;
            if (rcol_q + 1 >= hcols_q) begin
              rcol_q <= '0;
              rrow_q <= rrow_q + 1'b1;
            end else rcol_q <= rcol_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `BDT_ASSERT_NEVER(a_out_hold, clk_i, rst_ni, out_v_q && in_ch.ready, "input taken while result pending")
  `BDT_ASSERT_NEVER(a_nr_shape, clk_i, rst_ni, out_v_q && out_q.not_ready && out_q.last, "not-ready beat flagged last")
  `BDT_ASSERT_IMPL(a_ready_blocks, clk_i, rst_ni, (state_q != S_IDLE) |-> !in_ch.ready, "ready outside idle")
endmodule

/* sim/tb_bounded_distance_transform_2d.sv */
// testbench for bounded_distance_transform_2d: random frames checked against a predictor
`timescale 1ns / 1ps
module tb_bounded_distance_transform_2d;
  import bdt_pkg::*;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned HALF_WIN = 4;
  localparam int unsigned QUIET_LIMIT = 20000;

  class dt_scoreboard;
    out_beat_t   want_q[$];
    longint      score_mem[DEPTH];
    longint      colmax_mem[DEPTH];
    int unsigned colarg_mem[DEPTH];
    longint      resval_mem[DEPTH];
    int unsigned rescol_mem[DEPTH];
    int unsigned rows_reg, cols_reg, held_rows, held_cols, load_cnt, read_cnt;
    bit          frame_done;
    longint      ax, bx, ay, by;
    int          errors;

    function new();
      rows_reg = 64;
      cols_reg = 64;
      held_rows = 64;
      held_cols = 64;
    endfunction

    static function int unsigned fit_dim(int unsigned v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_ROWS: rows_reg = v[6:0];
        CFG_COLS: cols_reg = v[6:0];
        CFG_AX:   ax = longint'(signed'(v));
        CFG_BX:   bx = longint'(signed'(v));
        CFG_AY:   ay = longint'(signed'(v));
        CFG_BY:   by = longint'(signed'(v));
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // bounded max filter along one line; second selects the row sweep
    function void sweep(bit second, int base, int stride, int n, longint a, longint b);
      int     lo, hi, best_j;
      longint best, v, d, cand;
      bit     have;
      for (int i = 0; i < n; i++) begin
        lo = (i - int'(HALF_WIN) < 0) ? 0 : i - int'(HALF_WIN);
        hi = (i + int'(HALF_WIN) > n - 1) ? n - 1 : i + int'(HALF_WIN);
        have = 0;
        best = 0;
        best_j = lo;
        for (int j = lo; j <= hi; j++) begin
          v = second ? colmax_mem[base + j * stride] : score_mem[base + j * stride];
          d = i - j;
          cand = v - a * (d * d) - b * d;
          if (!have || cand > best) begin
            best = cand;
            best_j = j;
            have = 1;
          end
        end
        if (second) begin
          resval_mem[base + i * stride] = clip32(best);
          rescol_mem[base + i * stride] = best_j;
        end else begin
          colmax_mem[base + i * stride] = clip32(best);
          colarg_mem[base + i * stride] = best_j;
        end
      end
    endfunction

    function void note_beat(in_beat_t b);
      out_beat_t   w;
      int unsigned k, r, col;
      w = '0;
      if (b.kind == 1'b0) begin
        if (frame_done) return;
        if (load_cnt < DEPTH) score_mem[load_cnt] = longint'(b.score);
        load_cnt++;
        if (load_cnt >= fit_dim(rows_reg) * fit_dim(cols_reg)) begin
          held_rows = fit_dim(rows_reg);
          held_cols = fit_dim(cols_reg);
          for (int c = 0; c < int'(held_cols); c++)
            sweep(0, c, held_cols, held_rows, ay, by);
          for (int rr = 0; rr < int'(held_rows); rr++)
            sweep(1, rr * held_cols, 1, held_cols, ax, bx);
          frame_done = 1;
          read_cnt = 0;
        end
        return;
      end
      if (!frame_done) begin
        w.not_ready = 1'b1;
        want_q.push_back(w);
        return;
      end
      k = read_cnt;
      r = k / held_cols;
      col = rescol_mem[k];
      w.value = resval_mem[k][31:0];
      w.col_index = col[IdxW-1:0];
      w.row_index = colarg_mem[r * held_cols + col][IdxW-1:0];
      w.last = (read_cnt + 1 >= held_rows * held_cols);
      want_q.push_back(w);
      if (w.last) begin
        frame_done = 0;
        load_cnt = 0;
        read_cnt = 0;
      end else begin
        read_cnt++;
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t w;
      if (want_q.size() == 0) begin
        report("unexpected result beat, value", got.value, 0);
        return;
      end
      w = want_q.pop_front();
      if (got.value !== w.value) report("value", got.value, w.value);
      if (got.col_index !== w.col_index) report("col_index", got.col_index, w.col_index);
      if (got.row_index !== w.row_index) report("row_index", got.row_index, w.row_index);
      if (got.last !== w.last) report("last", got.last, w.last);
      if (got.not_ready !== w.not_ready) report("not_ready", got.not_ready, w.not_ready);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ScoreW-1:0]  cfg_data_i;

  bdt_in_if  in_ch ();
  bdt_out_if out_ch ();

  bounded_distance_transform_2d i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  dt_scoreboard sb = new();
  int           items;
  int           hold_req;
  int           quiet_cycles;
  bit           in_up;
  bit           no_gaps;
  bit           extreme_scores;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int idle_left;
    int r;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_beat(out_ch.data);
      if (hold_req > 0) begin
        idle_left = hold_req;
        hold_req = 0;
      end
      if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r >= 95) idle_left = $urandom_range(10, 40);
        else if (r >= 65) idle_left = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** bounded_distance_transform_2d: FAILED **");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] draw_score();
    logic [31:0] pick[4];
    pick = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    if (extreme_scores) return pick[$urandom_range(0, 3)];
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 32'h40000) - 32'h20000;
      1: return pick[$urandom_range(0, 3)];
      2: return $urandom_range(0, 1) << 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] draw_coeff();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return $urandom_range(0, 32'h40000);
      2: return -$urandom_range(0, 32'h40000);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_beat(bit k, logic [31:0] s);
    in_beat_t b;
    int       gap;
    b.kind = k;
    b.score = s;
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    in_up = 1;
    do @(posedge clk_i); while (!in_ch.ready);
    if (k || !sb.frame_done) items++;
    sb.note_beat(b);
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_up = 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (in_up) begin
      in_ch.valid <= 1'b0;
      in_up = 0;
    end
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_set(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic run_frame(int unsigned rows, int unsigned cols, logic [31:0] ax,
                           logic [31:0] bx, logic [31:0] ay, logic [31:0] by,
                           int noise_pct, int hold);
    int unsigned n;
    drain_results();
    cfg_set(CFG_ROWS, rows);
    cfg_set(CFG_COLS, cols);
    cfg_set(CFG_AX, ax);
    cfg_set(CFG_BX, bx);
    cfg_set(CFG_AY, ay);
    cfg_set(CFG_BY, by);
    cfg_we_i <= 1'b0;
    n = dt_scoreboard::fit_dim(rows) * dt_scoreboard::fit_dim(cols);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) push_beat(1'b1, $urandom());
      push_beat(1'b0, draw_score());
    end
    if (hold > 0) hold_req = hold;
    for (int unsigned i = 0; i < n; i++) begin
      // loads while the frame is held are dropped
      if ($urandom_range(0, 99) < noise_pct) push_beat(1'b0, $urandom());
      push_beat(1'b1, $urandom());
    end
  endtask

  initial begin
    int unsigned rows, cols;
    items = 0;
    hold_req = 0;
    quiet_cycles = 0;
    in_up = 0;
    no_gaps = 0;
    extreme_scores = 1;
    @(posedge rst_ni);
    @(posedge clk_i);
    push_beat(1'b1, 32'h0);
    run_frame(2, 3, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 100, 0);
    run_frame(0, 0, 32'h0, 32'h0, 32'h0, 32'h0, 100, 0);
    extreme_scores = 0;
    run_frame(3, 4, draw_coeff(), draw_coeff(), draw_coeff(), draw_coeff(), 5, 1500);
    run_frame(127, 1, draw_coeff(), draw_coeff(), draw_coeff(), draw_coeff(), 5, 0);
    run_frame(1, 64, draw_coeff(), draw_coeff(), draw_coeff(), draw_coeff(), 5, 0);
    no_gaps = 1;
    run_frame(64, 2, draw_coeff(), draw_coeff(), draw_coeff(), draw_coeff(), 0, 0);
    no_gaps = 0;
    while (items < 1000) begin
      rows = $urandom_range(1, 7);
      cols = $urandom_range(1, 7);
      no_gaps = ($urandom_range(0, 4) == 0);
      run_frame(rows, cols, draw_coeff(), draw_coeff(), draw_coeff(), draw_coeff(),
                5, ($urandom_range(0, 30) == 0) ? 300 : 0);
    end
    drain_results();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("** bounded_distance_transform_2d: PASSED **");
    end else begin
      $display("** bounded_distance_transform_2d: FAILED **");
    end
    $finish;
  end
endmodule
